// ===== src/set_assoc_lru_writeback_tag_array_defines.svh =====
// Assertion macros shared by the tag array
`ifndef SET_ASSOC_LRU_WRITEBACK_TAG_ARRAY_DEFINES_SVH
`define SET_ASSOC_LRU_WRITEBACK_TAG_ARRAY_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define SALT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tag array check failed");

// Next-cycle implication checked outside reset
`define SALT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tag array check failed");

`endif

// ===== src/salt_pkg.sv =====
`default_nettype none
package salt_pkg;

  localparam int unsigned SETS_DEF        = 256;
  localparam int unsigned WAYS_DEF        = 4;
  localparam int unsigned BLOCK_BYTES_DEF = 64;
  localparam int unsigned ADDR_BITS_DEF   = 32;

  typedef enum logic [2:0] {
    OP_LOAD   = 3'd0,
    OP_STORE  = 3'd1,
    OP_EVICT  = 3'd2,
    OP_PROBE  = 3'd3,
    OP_INSERT = 3'd4,
    OP_LOOKUP = 3'd5,
    OP_RSVD6  = 3'd6,
    OP_RSVD7  = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    KIND_DONE   = 3'd0,
    KIND_MISS   = 3'd1,
    KIND_WB     = 3'd2,
    KIND_PROBE  = 3'd3,
    KIND_CLEAN  = 3'd4,
    KIND_FORCED = 3'd5
  } kind_t;

  localparam logic [2:0] ROLE_L1D     = 3'd2;
  localparam logic [2:0] ROLE_L2      = 3'd4;
  localparam logic [2:0] SRC_PREFETCH = 3'd5;

  // One classified request in the queue between front and back
  typedef struct packed {
    op_t         op;
    logic [31:0] address;
    logic [2:0]  requester;
    logic        set_dirty;
    logic        is_prefetch;
  } req_t;

  // One result item
  typedef struct packed {
    kind_t       kind;
    logic [31:0] maddr;
    logic [2:0]  src;
    logic        hit;
    logic        last;
  } res_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } bst_t;

  function automatic int unsigned clog2c(input int unsigned v);
    int unsigned n;
    n = 0;
    while ((32'd1 << n) < v) n++;
    return (n == 0) ? 1 : n;
  endfunction

  function automatic int unsigned flog2(input int unsigned v);
    int unsigned n;
    n = 0;
    while ((v >> (n + 1)) != 0) n++;
    return n;
  endfunction

endpackage
`default_nettype wire

// ===== src/salt_ram.sv =====
`default_nettype none
module salt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one registered
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== src/salt_queue.sv =====
`default_nettype none
module salt_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire salt_pkg::req_t push_data,
  output logic               full,
  input  wire logic          pop,
  output salt_pkg::req_t     pop_data,
  output logic               not_empty
);
  import salt_pkg::*;

  req_t       ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_data  = ent_r[rp_r];

  // Two-entry queue between the front and back parts
  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_data;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ===== src/salt_front.sv =====
`default_nettype none
module salt_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire logic [39:0]    in_tdata,
  input  wire logic [2:0]     in_tuser,
  output logic                push,
  output salt_pkg::req_t      push_data,
  input  wire logic           full
);
  import salt_pkg::*;

  logic unused_clk;
  logic unused_pad;
  assign unused_clk = clk & rst_n;
  assign unused_pad = |in_tdata[39:37];

  // Accept and unpack while the queue has room
  assign in_tready = ~full;
  assign push      = in_tvalid & ~full;
  always_comb begin
    push_data.op          = op_t'(in_tuser);
    push_data.address     = in_tdata[31:0];
    push_data.requester   = in_tdata[34:32];
    push_data.set_dirty   = in_tdata[35];
    push_data.is_prefetch = in_tdata[36];
  end
endmodule
`default_nettype wire

// ===== src/salt_back.sv =====
`default_nettype none
module salt_back #(
  parameter int unsigned SETS        = salt_pkg::SETS_DEF,
  parameter int unsigned WAYS        = salt_pkg::WAYS_DEF,
  parameter int unsigned BLOCK_BYTES = salt_pkg::BLOCK_BYTES_DEF,
  parameter int unsigned ADDR_BITS   = salt_pkg::ADDR_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [2:0]     role,
  input  wire logic           req_valid,
  input  wire salt_pkg::req_t req,
  output logic                req_pop,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output salt_pkg::res_t      res,
  output logic                busy
);
  import salt_pkg::*;

  localparam int unsigned OFFB  = flog2(BLOCK_BYTES);
  localparam int unsigned IDXB  = flog2(SETS);
  localparam int unsigned NSETS = 1 << IDXB;
  localparam int unsigned SW    = (IDXB == 0) ? 1 : IDXB;
  localparam int unsigned AW    = (ADDR_BITS < 32) ? ADDR_BITS : 32;
  localparam logic [31:0] AMASK = (AW >= 32) ? 32'hFFFF_FFFF :
                                  32'((64'd1 << AW) - 64'd1);
  localparam int unsigned TAGB  = AW - OFFB - IDXB;
  localparam int unsigned WW    = clog2c(WAYS);
  localparam int unsigned LINEW = TAGB + 5;   // tag, valid, dirty, owner
  localparam int unsigned ROWW  = LINEW * WAYS + WW * WAYS;

  typedef struct packed {
    logic [TAGB-1:0] tag;
    logic            valid;
    logic            dirty;
    logic [2:0]      owner;
  } line_t;

  bst_t st_r, st_nxt;
  req_t cur_r;
  logic [SW-1:0] clr_r;
  res_t q_r [4];
  logic [2:0] qn_r, qi_r;
  logic we;
  logic [SW-1:0] waddr, raddr, set_idx;
  logic [ROWW-1:0] wrow, rrow;
  logic [31:0] addr_m;

  line_t lines [WAYS];
  line_t nlines [WAYS];
  logic [WW-1:0] ord [WAYS];
  logic [WW-1:0] nord [WAYS];
  logic [TAGB-1:0] tag;
  logic hitf;
  logic [WW-1:0] hway, vway, tway;
  res_t nq [4];
  logic [2:0] nn;
  logic [31:0] vaddr;
  logic tomru, tolru;
  logic [WW-1:0] pos;

  // Keep only the address bits inside the address space
  assign addr_m  = cur_r.address & AMASK;
  assign set_idx = (IDXB == 0) ? '0 : SW'(addr_m >> OFFB);
  assign tag     = TAGB'(addr_m >> (OFFB + IDXB));
  assign raddr   = (IDXB == 0) ? '0 : SW'((req.address & AMASK) >> OFFB);

  salt_ram #(.WIDTH(ROWW), .DEPTH(NSETS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wrow), .raddr(raddr), .rdata(rrow)
  );

  // Unpack the set row, look up, update, build results
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      lines[w] = rrow[w*LINEW +: LINEW];
      ord[w]   = rrow[LINEW*WAYS + w*WW +: WW];
    end
    hitf = 1'b0;
    hway = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (lines[w].valid && lines[w].tag == tag) begin
        hitf = 1'b1;
        hway = WW'(w);
      end
    end
    vway = ord[0];
    nlines = lines;
    nord   = ord;
    tomru = 1'b0;
    tolru = 1'b0;
    tway  = hway;
    nn = 3'd0;
    for (int k = 0; k < 4; k++) nq[k] = '0;
    vaddr = 32'({lines[vway].tag, set_idx}) << OFFB;
    if (IDXB == 0) vaddr = 32'(lines[vway].tag) << OFFB;
    unique case (cur_r.op)
      OP_LOAD, OP_STORE, OP_INSERT: begin
        if (hitf && cur_r.op != OP_INSERT) begin
          tomru = 1'b1;
          if (cur_r.op == OP_STORE && role == ROLE_L1D) nlines[hway].dirty = 1'b1;
        end else begin
          tway = vway;
          tomru = 1'b1;
          if (lines[vway].valid) begin
            nq[nn[1:0]] = '{kind: lines[vway].dirty ? KIND_WB : KIND_CLEAN,
                            maddr: vaddr, src: role, hit: 1'b0, last: 1'b0};
            nn = nn + 3'd1;
            if (role == ROLE_L2) begin
              nq[nn[1:0]] = '{kind: KIND_PROBE, maddr: vaddr,
                              src: (cur_r.op == OP_INSERT && cur_r.is_prefetch) ?
                                   SRC_PREFETCH : lines[vway].owner,
                              hit: 1'b0, last: 1'b0};
              nn = nn + 3'd1;
            end
          end
          if (cur_r.op != OP_INSERT) begin
            nq[nn[1:0]] = '{kind: KIND_MISS, maddr: addr_m, src: role,
                            hit: 1'b0, last: 1'b0};
            nn = nn + 3'd1;
          end
          nlines[vway].tag   = tag;
          nlines[vway].valid = 1'b1;
          nlines[vway].owner = cur_r.requester;
          nlines[vway].dirty = (cur_r.op == OP_INSERT) ? cur_r.set_dirty :
                               (cur_r.op == OP_STORE && role == ROLE_L1D);
        end
      end
      OP_EVICT: if (hitf) nlines[hway].dirty = 1'b1;
      OP_PROBE: begin
        if (hitf) begin
          if (lines[hway].dirty) begin
            nq[nn[1:0]] = '{kind: KIND_FORCED, maddr: addr_m, src: role,
                            hit: 1'b0, last: 1'b0};
            nn = nn + 3'd1;
          end
          nlines[hway].valid = 1'b0;
          nlines[hway].owner = 3'd0;
          tolru = 1'b1;
        end
      end
      default: ;
    endcase
    nq[nn[1:0]] = '{kind: KIND_DONE, maddr: 32'd0, src: 3'd0,
                    hit: hitf && (cur_r.op != OP_RSVD6) && (cur_r.op != OP_RSVD7),
                    last: 1'b1};
    nn = nn + 3'd1;
    // Recency shift toward MRU or LRU end
    pos = '0;
    for (int i = 0; i < WAYS; i++) if (ord[i] == tway) pos = WW'(i);
    if (tomru) begin
      for (int i = 0; i < WAYS - 1; i++) if (i >= pos) nord[i] = ord[i+1];
      nord[WAYS-1] = tway;
    end else if (tolru) begin
      for (int i = WAYS - 1; i > 0; i--) if (i <= pos) nord[i] = ord[i-1];
      nord[0] = tway;
    end
  end

  // Pack the row to write, or the reset row while clearing
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      wrow[w*LINEW +: LINEW] = (st_r == ST_CLEAR) ? '0 : nlines[w];
      wrow[LINEW*WAYS + w*WW +: WW] = (st_r == ST_CLEAR) ? WW'(w) : nord[w];
    end
  end

  assign waddr = (st_r == ST_CLEAR) ? clr_r : set_idx;
  assign res   = q_r[qi_r[1:0]];
  assign busy  = (st_r != ST_IDLE);

  // Sequencer: clear, read set, update and emit
  always_comb begin
    st_nxt     = st_r;
    we         = 1'b0;
    req_pop    = 1'b0;
    out_tvalid = 1'b0;
    unique case (st_r)
      ST_CLEAR: begin
        we = 1'b1;
        if (clr_r == SW'(NSETS - 1)) st_nxt = ST_IDLE;
      end
      ST_IDLE: if (req_valid) begin
        req_pop = 1'b1;
        st_nxt  = ST_READ;
      end
      ST_READ: begin
        we     = 1'b1;
        st_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        out_tvalid = 1'b1;
        if (out_tready && qi_r + 3'd1 == qn_r) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (req_pop) cur_r <= req;
    if (st_r == ST_READ) for (int k = 0; k < 4; k++) q_r[k] <= nq[k];
    if (!rst_n) begin
      st_r  <= ST_CLEAR;
      clr_r <= '0;
      qn_r  <= 3'd0;
      qi_r  <= 3'd0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_CLEAR) clr_r <= clr_r + SW'(1);
      if (st_r == ST_READ) begin
        qn_r <= nn;
        qi_r <= 3'd0;
      end else if (st_r == ST_EMIT && out_tready) begin
        qi_r <= qi_r + 3'd1;
      end
    end
  end
endmodule
`default_nettype wire

// ===== src/set_assoc_lru_writeback_tag_array.sv =====
// Channel | Dir | Payload
// in_     | in  | tuser op; tdata {is_prefetch, set_dirty, requester, address}, 40 bits
// out_    | out | tuser kind; tdata {hit, message_source, message_address}; tlast last
// cfg_    | in  | cache_role, 3 bits
// An item holds the back part through the queue pop with the registered set read from the
// tag RAM, the set update, then the drain of its 1 to 4 results; the next pop waits for it.
// The first result is offered once the item has passed the queue, the pop, the set read and the set update.
// After reset a clearing pass writes every set before items start.
// The two-entry queue keeps accepting while results stall; when full, in_tready drops.
`default_nettype none
`include "set_assoc_lru_writeback_tag_array_defines.svh"
module set_assoc_lru_writeback_tag_array #(
  parameter int unsigned SETS        = salt_pkg::SETS_DEF,
  parameter int unsigned WAYS        = salt_pkg::WAYS_DEF,
  parameter int unsigned BLOCK_BYTES = salt_pkg::BLOCK_BYTES_DEF,
  parameter int unsigned ADDR_BITS   = salt_pkg::ADDR_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // address, requester, set_dirty, is_prefetch, zero pad
  input  wire logic [2:0]  in_tuser,   // op
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // message_address, message_source, hit, zero pad
  output logic [2:0]       out_tuser,  // kind
  output logic             out_tlast,  // last
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_wdata   // cache_role
);
  import salt_pkg::*;

  logic [2:0] role_r;
  logic push, full, pop, ne, busy;
  req_t pd, qd;
  res_t res;

  // Hold the role register
  always_ff @(posedge clk) begin
    if (!rst_n) role_r <= ROLE_L1D;
    else if (cfg_we) role_r <= cfg_wdata;
  end

  salt_front u_front (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser), .push(push), .push_data(pd), .full(full)
  );

  salt_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(pd), .full(full),
    .pop(pop), .pop_data(qd), .not_empty(ne)
  );

  salt_back #(.SETS(SETS), .WAYS(WAYS), .BLOCK_BYTES(BLOCK_BYTES),
              .ADDR_BITS(ADDR_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .role(role_r), .req_valid(ne), .req(qd),
    .req_pop(pop), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .res(res), .busy(busy)
  );

  assign out_tdata = {4'b0000, res.hit, res.src, res.maddr};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

  `SALT_ASSERT_IMPL(a_done_last, clk, rst_n, out_tvalid && out_tlast, out_tuser == KIND_DONE)
  `SALT_ASSERT_IMPL(a_pop_idle, clk, rst_n, pop, !busy && ne)
  `SALT_ASSERT_NEXT(a_pop_busy, clk, rst_n, pop, busy && !out_tvalid)
endmodule
`default_nettype wire

// ===== test/set_assoc_lru_writeback_tag_array_tb.sv =====
`default_nettype none
module set_assoc_lru_writeback_tag_array_tb;
  import salt_pkg::*;

  localparam int NSETS   = 256;
  localparam int NWAYS   = 4;
  localparam int OFFB    = 6;
  localparam int IDXB    = 8;
  localparam int WDOG    = 4000;
  localparam int NROWS   = 32;
  localparam logic [2:0] ROLE_L1I = 3'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_wdata = 3'd0;

  set_assoc_lru_writeback_tag_array dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the tag array
  logic [17:0] tag_mem   [NSETS][NWAYS];
  logic        valid_mem [NSETS][NWAYS];
  logic        dirty_mem [NSETS][NWAYS];
  logic [2:0]  owner_mem [NSETS][NWAYS];
  logic [1:0]  lru_order [NSETS][NWAYS];
  logic [2:0]  role;

  // Ring of expected results, oldest at exp_head
  res_t exp_buf [64];
  int   exp_head = 0;
  int   exp_tail = 0;
  int   errors = 0;
  int   n_items = 0;
  int   n_msgs = 0;
  int   idle_cycles = 0;
  int   in_idle_pct = 0;
  int   out_stall_pct = 0;

  function automatic res_t mk(kind_t k, logic [31:0] a, logic [2:0] s, logic h, logic l);
    res_t r;
    r.kind = k; r.maddr = a; r.src = s; r.hit = h; r.last = l;
    return r;
  endfunction

  function automatic void exp_add(res_t r);
    exp_buf[6'(exp_tail)] = r;
    exp_tail++;
  endfunction

  function automatic res_t exp_take();
    res_t r;
    r = exp_buf[6'(exp_head)];
    exp_head++;
    return r;
  endfunction

  function automatic void touch_mru(int st, int w);
    int p;
    p = 0;
    for (int i = 0; i < NWAYS; i++) if (lru_order[st][i] == w) p = i;
    for (int i = p; i < NWAYS - 1; i++) lru_order[st][i] = lru_order[st][i + 1];
    lru_order[st][NWAYS - 1] = 2'(w);
  endfunction

  function automatic void touch_lru(int st, int w);
    int p;
    p = 0;
    for (int i = 0; i < NWAYS; i++) if (lru_order[st][i] == w) p = i;
    for (int i = p; i > 0; i--) lru_order[st][i] = lru_order[st][i - 1];
    lru_order[st][0] = 2'(w);
  endfunction

  function automatic void clear_shadow();
    for (int s = 0; s < NSETS; s++)
      for (int w = 0; w < NWAYS; w++) begin
        tag_mem[s][w] = '0; valid_mem[s][w] = 1'b0; dirty_mem[s][w] = 1'b0;
        owner_mem[s][w] = '0; lru_order[s][w] = 2'(w);
      end
    role = ROLE_L1D;
  endfunction

  // Victim notice plus probe up in the L2 role
  function automatic void push_victim(int st, int w, logic pf);
    logic [31:0] va;
    va = {tag_mem[st][w], st[IDXB-1:0], {OFFB{1'b0}}};
    exp_add(mk(dirty_mem[st][w] ? KIND_WB : KIND_CLEAN, va, role, 1'b0, 1'b0));
    if (role == ROLE_L2)
      exp_add(mk(KIND_PROBE, va, pf ? SRC_PREFETCH : owner_mem[st][w], 1'b0, 1'b0));
  endfunction

  function automatic void predict_access(req_t rq);
    int st, w, v;
    logic [17:0] tg;
    logic h;
    st = rq.address[OFFB +: IDXB];
    tg = rq.address[31:OFFB+IDXB];
    w = -1;
    for (int i = NWAYS - 1; i >= 0; i--)
      if (valid_mem[st][i] && tag_mem[st][i] == tg) w = i;
    h = (w >= 0);
    v = lru_order[st][0];
    case (rq.op)
      OP_LOAD, OP_STORE: begin
        if (h) begin
          touch_mru(st, w);
          if (rq.op == OP_STORE && role == ROLE_L1D) dirty_mem[st][w] = 1'b1;
        end else begin
          if (valid_mem[st][v]) push_victim(st, v, 1'b0);
          exp_add(mk(KIND_MISS, rq.address, role, 1'b0, 1'b0));
          dirty_mem[st][v] = (rq.op == OP_STORE && role == ROLE_L1D);
          valid_mem[st][v] = 1'b1; owner_mem[st][v] = rq.requester; tag_mem[st][v] = tg;
          touch_mru(st, v);
        end
      end
      OP_EVICT: if (h) dirty_mem[st][w] = 1'b1;
      OP_PROBE: if (h) begin
        if (dirty_mem[st][w])
          exp_add(mk(KIND_FORCED, rq.address, role, 1'b0, 1'b0));
        valid_mem[st][w] = 1'b0; owner_mem[st][w] = '0;
        touch_lru(st, w);
      end
      OP_INSERT: begin
        if (valid_mem[st][v]) push_victim(st, v, rq.is_prefetch);
        dirty_mem[st][v] = rq.set_dirty; valid_mem[st][v] = 1'b1;
        tag_mem[st][v] = tg; owner_mem[st][v] = rq.requester;
        touch_mru(st, v);
      end
      OP_LOOKUP: ;
      default: h = 1'b0;
    endcase
    exp_add(mk(KIND_DONE, '0, '0, h, 1'b1));
  endfunction

  // Send one request; optional typed expectation replaces the predicted final result
  task automatic send_req(req_t rq, bit fixed, res_t fixed_res);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= {3'b000, rq.is_prefetch, rq.set_dirty, rq.requester, rq.address};
    in_tuser  <= rq.op;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_access(rq);
    if (fixed) exp_buf[6'(exp_tail - 1)] = fixed_res;
    n_items++;
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (exp_tail != exp_head) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_role(logic [2:0] r);
    wait_drain();
    cfg_wdata <= r;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    role = r;
  endtask

  // Receiver stall and result checking
  always @(posedge clk) begin
    if (rst_n) begin
      out_tready <= ($urandom_range(99) >= out_stall_pct);
      if (out_tvalid && out_tready) begin
        res_t got, want;
        got = mk(kind_t'(out_tuser), out_tdata[31:0], out_tdata[34:32],
                 out_tdata[35], out_tlast);
        n_msgs++;
        if (exp_tail == exp_head) begin
          $error("unexpected result kind=%0d addr=%h", got.kind, got.maddr);
          errors++;
        end else begin
          want = exp_take();
          if (got.kind != want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, got.kind); errors++;
          end
          if (got.maddr != want.maddr) begin
            $error("message_address: expected %h, actual %h", want.maddr, got.maddr);
            errors++;
          end
          if (got.src != want.src) begin
            $error("message_source: expected %0d, actual %0d", want.src, got.src); errors++;
          end
          if (got.hit != want.hit) begin
            $error("hit: expected %0d, actual %0d", want.hit, got.hit); errors++;
          end
          if (got.last != want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got.last); errors++;
          end
        end
      end
    end
  end

  // Watchdog on transfers; allows for the clearing pass after reset
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] mkaddr(logic [17:0] tg, logic [7:0] st, logic [5:0] off);
    return {tg, st, off};
  endfunction

  // Directed stimulus table
  typedef struct {
    req_t rq;
    bit   fixed;
    res_t res;
  } stim_row_t;

  stim_row_t dir_rows [NROWS];
  int        n_rows = 0;

  function automatic req_t rqm(op_t o, logic [31:0] a, logic [2:0] rqr, logic sd, logic pf);
    req_t r;
    r.op = o; r.address = a; r.requester = rqr; r.set_dirty = sd; r.is_prefetch = pf;
    return r;
  endfunction

  function automatic void add_row(req_t r, bit f, res_t e);
    stim_row_t s;
    s.rq = r; s.fixed = f; s.res = e;
    dir_rows[n_rows] = s;
    n_rows++;
  endfunction

  function automatic req_t rand_req(int phase);
    req_t r;
    logic [7:0] st;
    st = (phase == 0) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
    // Narrow tags, and narrow sets in even phases, keep hits and evictions frequent
    r.address = {($urandom_range(3) == 0) ? 18'($urandom) : 18'($urandom_range(5)),
                 st, 6'($urandom)};
    r.op = op_t'(($urandom_range(19) == 0) ? $urandom_range(7, 6) : $urandom_range(5));
    r.requester = 3'($urandom_range(7));
    r.set_dirty = 1'($urandom);
    r.is_prefetch = 1'($urandom);
    return r;
  endfunction

  initial begin
    res_t done0, done1;
    clear_shadow();
    done0 = mk(KIND_DONE, '0, '0, 1'b0, 1'b1);
    done1 = mk(KIND_DONE, '0, '0, 1'b1, 1'b1);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: misses after reset, hits, extremes, every op and corner case
    add_row(rqm(OP_LOOKUP, 32'h0, 3'd0, 1'b0, 1'b0), 1, done0);
    add_row(rqm(OP_PROBE, 32'hFFFF_FFFF, 3'd7, 1'b1, 1'b1), 1, done0);
    add_row(rqm(OP_EVICT, 32'h0000_0040, 3'd1, 1'b0, 1'b0), 1, done0);
    add_row(rqm(OP_RSVD6, 32'h0, 3'd0, 1'b0, 1'b0), 1, done0);
    add_row(rqm(OP_RSVD7, 32'hFFFF_FFFF, 3'd7, 1'b1, 1'b1), 1, done0);
    add_row(rqm(OP_LOAD, mkaddr(18'h3FFFF, 8'hFF, 6'h3F), 3'd1, 1'b0, 1'b0), 0, done0);
    add_row(rqm(OP_LOAD, mkaddr(18'h3FFFF, 8'hFF, 6'h00), 3'd1, 1'b0, 1'b0), 1, done1);
    add_row(rqm(OP_STORE, mkaddr(18'h0, 8'h0, 6'h1), 3'd2, 1'b0, 1'b0), 0, done0);
    add_row(rqm(OP_STORE, mkaddr(18'h0, 8'h0, 6'h2), 3'd2, 1'b0, 1'b0), 1, done1);
    for (int t = 1; t <= 4; t++)
      add_row(rqm(OP_LOAD, mkaddr(18'(t), 8'h0, 6'h0), 3'(t), 1'b0, 1'b0), 0, done0);
    add_row(rqm(OP_EVICT, mkaddr(18'd4, 8'h0, 6'h0), 3'd3, 1'b0, 1'b0), 1, done1);
    add_row(rqm(OP_PROBE, mkaddr(18'd4, 8'h0, 6'h15), 3'd0, 1'b0, 1'b0), 0, done0);
    add_row(rqm(OP_PROBE, mkaddr(18'd3, 8'h0, 6'h0), 3'd0, 1'b0, 1'b0), 0, done0);
    add_row(rqm(OP_INSERT, mkaddr(18'd2, 8'h0, 6'h0), 3'd5, 1'b1, 1'b1), 0, done0);
    add_row(rqm(OP_INSERT, mkaddr(18'd2, 8'h0, 6'h0), 3'd4, 1'b0, 1'b0), 0, done0);
    add_row(rqm(OP_LOOKUP, mkaddr(18'd2, 8'h0, 6'h0), 3'd0, 1'b0, 1'b0), 1, done1);
    add_row(rqm(OP_PROBE, mkaddr(18'd2, 8'h0, 6'h0), 3'd0, 1'b0, 1'b0), 0, done0);
    add_row(rqm(OP_LOOKUP, mkaddr(18'd2, 8'h0, 6'h0), 3'd0, 1'b0, 1'b0), 0, done0);
    for (int i = 0; i < n_rows; i++)
      send_req(dir_rows[i].rq, dir_rows[i].fixed, dir_rows[i].res);

    // Random phases across roles, with the idling pattern rotating
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_role(ROLE_L2);
        1: write_role(ROLE_L1I);
        2: write_role(3'd0);
        3: write_role(3'd7);
        4: write_role(ROLE_L1D);
        default: write_role(ROLE_L2);
      endcase
      in_idle_pct   = (ph % 3 == 0) ? 20 : (ph % 3 == 1) ? 66 : 0;
      out_stall_pct = (ph % 3 == 0) ? 66 : (ph % 3 == 1) ? 20 : 0;
      for (int i = 0; i < 30; i++) send_req(rand_req(ph % 2), 0, done0);
    end

    wait_drain();
    $display("Sent %0d requests across all cache roles, %0d results checked.",
             n_items, n_msgs);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
`default_nettype wire

// ===== set_assoc_lru_writeback_tag_array.f =====
+incdir+src
src/salt_pkg.sv
src/salt_ram.sv
src/salt_queue.sv
src/salt_front.sv
src/salt_back.sv
src/set_assoc_lru_writeback_tag_array.sv
test/set_assoc_lru_writeback_tag_array_tb.sv
